// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the route lookup RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold on every clock outside reset.
`define RLPM_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Same-cycle implication.
`define RLPM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define RLPM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/rlpm_pkg.sv -----
// Shared types, constants and helpers of the route lookup block.
`default_nettype none

package rlpm_pkg;

  localparam int DEF_ENTRIES = 16;
  localparam int SLOT_W      = 4;
  localparam int SLOT_CNT    = 2 ** SLOT_W;
  localparam int ADDR_W      = 32;
  localparam int LEN_W       = 6;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  typedef enum logic [1:0] {
    ACT_DELIVER = 2'd0,
    ACT_FORWARD = 2'd1,
    ACT_DROP    = 2'd2,
    ACT_LOCAL   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } scan_state_t;

  // One route as kept in the table memory; len is the mask popcount.
  typedef struct packed {
    logic [ADDR_W-1:0] net;
    logic [ADDR_W-1:0] mask;
    logic [ADDR_W-1:0] gw;
    logic [ADDR_W-1:0] iface;
    logic [LEN_W-1:0]  len;
  } route_t;

  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] slot;
    logic              valid;
    route_t            route;
  } tbl_wr_t;

  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] addr;
  } tbl_rd_t;

  // Mask popcount: nibble counts, then an 8-term sum.
  function automatic logic [LEN_W-1:0] ones32(input logic [ADDR_W-1:0] m);
    logic [2:0]       nib [8];
    logic [LEN_W-1:0] sum;
    for (int i = 0; i < 8; i++) begin
      nib[i] = 3'(m[4*i]) + 3'(m[4*i+1]) + 3'(m[4*i+2]) + 3'(m[4*i+3]);
    end
    sum = '0;
    for (int i = 0; i < 8; i++) begin
      sum = sum + LEN_W'(nib[i]);
    end
    return sum;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/rlpm_if.sv -----
// Valid/ready channel interfaces for lookup requests and results.
`default_nettype none

interface rlpm_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [3:0]  slot;
  logic        entry_valid;
  logic [31:0] net_address;
  logic [31:0] net_mask;
  logic [31:0] gateway_address;
  logic [31:0] interface_address;
  logic [31:0] dest_ip;
  logic        local_origin;

  modport source (
    output valid, op, slot, entry_valid, net_address, net_mask, gateway_address,
           interface_address, dest_ip, local_origin,
    input  ready
  );
  modport sink (
    input  valid, op, slot, entry_valid, net_address, net_mask, gateway_address,
           interface_address, dest_ip, local_origin,
    output ready
  );
endinterface

interface rlpm_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic        route_found;
  logic [3:0]  route_slot;
  logic [5:0]  prefix_length;
  logic [31:0] hop_addr;
  logic [31:0] out_interface;

  modport source (
    output valid, action, route_found, route_slot, prefix_length, hop_addr,
           out_interface,
    input  ready
  );
  modport sink (
    input  valid, action, route_found, route_slot, prefix_length, hop_addr,
           out_interface,
    output ready
  );
endinterface

`default_nettype wire

// ----- rtl/rlpm_table.sv -----
// Route table: one synchronous route memory plus per-slot valid flops.
`default_nettype none
`include "assert_macros.svh"

module rlpm_table #(
  parameter int ENTRIES = rlpm_pkg::DEF_ENTRIES
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire rlpm_pkg::tbl_wr_t wr,
  input  wire rlpm_pkg::tbl_rd_t rd,
  output rlpm_pkg::route_t      rd_route,
  output logic                  rd_valid
);
  import rlpm_pkg::*;

  // Only slots reachable by the 4-bit slot field can ever hold a route.
  localparam int SLOTS = (ENTRIES < SLOT_CNT) ? ENTRIES : SLOT_CNT;
  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  route_t            mem [SLOTS];
  logic [SLOTS-1:0]  valid_r;
  route_t            rd_route_r;
  logic              rd_valid_r;

  logic [IDX_W-1:0]  widx;
  logic [IDX_W-1:0]  ridx;

  assign widx = wr.slot[IDX_W-1:0];
  assign ridx = rd.addr[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[widx] <= wr.route;
    end
    if (rd.en) begin
      rd_route_r <= mem[ridx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (wr.en) begin
        valid_r[widx] <= wr.valid;
      end
      if (rd.en) begin
        rd_valid_r <= valid_r[ridx];
      end
    end
  end

  assign rd_route = rd_route_r;
  assign rd_valid = rd_valid_r;

  // Writes land only while no scan is reading the memory.
  `RLPM_ASSERT_IMP(a_no_wr_rd_overlap, wr.en, !rd.en, "table write during scan read")

endmodule

`default_nettype wire

// ----- rtl/rlpm_scan.sv -----
// Lookup sequencer: accepts words, scans the table, keeps the best match.
`default_nettype none
`include "assert_macros.svh"

module rlpm_scan #(
  parameter int ENTRIES = rlpm_pkg::DEF_ENTRIES
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  rlpm_in_if.sink                in_ch,
  rlpm_out_if.source             out_ch,
  output rlpm_pkg::tbl_wr_t      wr,
  output rlpm_pkg::tbl_rd_t      rd,
  input  wire rlpm_pkg::route_t  rd_route,
  input  wire logic              rd_valid
);
  import rlpm_pkg::*;

  localparam int SLOTS = (ENTRIES < SLOT_CNT) ? ENTRIES : SLOT_CNT;
  localparam int CNT_W = $clog2(SLOTS + 1);

  scan_state_t       state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r;
  logic              rd_vld_r;
  logic [SLOT_W-1:0] rd_idx_r;

  logic [ADDR_W-1:0] dst_r;
  logic              local_r;
  logic              found_r;
  logic [SLOT_W-1:0] best_idx_r;
  logic [LEN_W-1:0]  best_len_r;
  logic [ADDR_W-1:0] best_gw_r;
  logic [ADDR_W-1:0] best_if_r;

  logic              out_valid_r;
  action_t           act_r;
  logic              found_o_r;
  logic [SLOT_W-1:0] slot_o_r;
  logic [LEN_W-1:0]  len_o_r;
  logic [ADDR_W-1:0] hop_o_r;
  logic [ADDR_W-1:0] if_o_r;

  logic              in_fire;
  logic              scan_last;
  logic              load_out;
  logic              hit;
  logic              better;
  action_t           act_nxt;
  logic [ADDR_W-1:0] hop_nxt;

  assign in_fire = in_ch.valid && in_ch.ready;
  assign hit     = rd_vld_r && rd_valid &&
                   (((dst_r ^ rd_route.net) & rd_route.mask) == '0);
  assign better  = hit && (!found_r || (rd_route.len > best_len_r));
  assign scan_last = (cnt_r == CNT_W'(SLOTS)) && !rd_vld_r;

  // Table write port: writes beyond the table are dropped.
  always_comb begin
    wr.en          = in_fire && (in_ch.op == OP_WRITE) &&
                     ({1'b0, in_ch.slot} < (SLOT_W+1)'(SLOTS));
    wr.slot        = in_ch.slot;
    wr.valid       = in_ch.entry_valid;
    wr.route.net   = in_ch.net_address;
    wr.route.mask  = in_ch.net_mask;
    wr.route.gw    = in_ch.gateway_address;
    wr.route.iface = in_ch.interface_address;
    wr.route.len   = ones32(in_ch.net_mask);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    in_ch.ready = 1'b0;
    rd.en       = 1'b0;
    rd.addr     = SLOT_W'(cnt_r);
    load_out    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid && (in_ch.op == OP_LOOKUP)) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        rd.en = (cnt_r < CNT_W'(SLOTS));
        if (scan_last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Result fields from the winning route, or the drop or local verdict when none matched.
  always_comb begin
    if (found_r) begin
      hop_nxt = (best_gw_r != '0) ? best_gw_r : dst_r;
      if (local_r) begin
        act_nxt = ACT_LOCAL;
      end else begin
        act_nxt = (best_gw_r != '0) ? ACT_FORWARD : ACT_DELIVER;
      end
    end else begin
      hop_nxt = '0;
      act_nxt = local_r ? ACT_LOCAL : ACT_DROP;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      rd_vld_r    <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rd_vld_r <= rd.en;
      if (in_fire && (in_ch.op == OP_LOOKUP)) begin
        cnt_r   <= '0;
        found_r <= 1'b0;
      end else begin
        if (rd.en) begin
          cnt_r <= cnt_r + 1'b1;
        end
        if (better) begin
          found_r <= 1'b1;
        end
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && (in_ch.op == OP_LOOKUP)) begin
      dst_r   <= in_ch.dest_ip;
      local_r <= in_ch.local_origin;
    end
    if (rd.en) begin
      rd_idx_r <= rd.addr;
    end
    if (better) begin
      best_idx_r <= rd_idx_r;
      best_len_r <= rd_route.len;
      best_gw_r  <= rd_route.gw;
      best_if_r  <= rd_route.iface;
    end
    if (load_out) begin
      act_r     <= act_nxt;
      found_o_r <= found_r;
      slot_o_r  <= found_r ? best_idx_r : '0;
      len_o_r   <= found_r ? best_len_r : '0;
      hop_o_r   <= hop_nxt;
      if_o_r    <= found_r ? best_if_r : '0;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.action        = act_r;
  assign out_ch.route_found   = found_o_r;
  assign out_ch.route_slot    = slot_o_r;
  assign out_ch.prefix_length = len_o_r;
  assign out_ch.hop_addr      = hop_o_r;
  assign out_ch.out_interface = if_o_r;

  `RLPM_ASSERT(a_cnt_bound, cnt_r <= CNT_W'(SLOTS), "scan counter past table end")
  `RLPM_ASSERT_NXT(a_lookup_starts, in_fire && (in_ch.op == OP_LOOKUP),
                   (state_r == ST_SCAN) && (cnt_r == '0) && !found_r,
                   "lookup did not start a fresh scan")
  `RLPM_ASSERT_IMP(a_full_scan, (state_r == ST_DONE) && ($past(state_r) == ST_SCAN),
                   (cnt_r == CNT_W'(SLOTS)) && !rd_vld_r,
                   "scan ended before every slot was checked")
  `RLPM_ASSERT_IMP(a_len_range, found_r, best_len_r <= LEN_W'(ADDR_W),
                   "winning prefix length out of range")

endmodule

`default_nettype wire

// ----- rtl/route_longest_prefix_match.sv -----
// Top level of the IPv4 longest-prefix-match route lookup.
//
//  channel | direction | words carried
//  --------+-----------+------------------------------------------------
//  in_ch   | in        | route write (op 0) or lookup request (op 1)
//  out_ch  | out       | one lookup result per lookup, none per write
//
//  A write word is accepted on any idle cycle.
//  A lookup holds off the next accept until its scan of min(ENTRIES,16) slots
//  ends and its result is loaded: the route memory delivers one entry per cycle on its read port.
//  A finished result waits in the output register; the next word is taken
//  meanwhile, and only a second result stalls until the first is taken.
//  Reset (rst_n low, synchronous) marks every slot invalid at once.

`default_nettype none

module route_longest_prefix_match #(
  parameter int ENTRIES = rlpm_pkg::DEF_ENTRIES
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  rlpm_in_if.sink    in_ch,
  rlpm_out_if.source out_ch
);
  import rlpm_pkg::*;

  tbl_wr_t tbl_wr;
  tbl_rd_t tbl_rd;
  route_t  tbl_route;
  logic    tbl_valid;

  // Sequencer: handshakes, scan counter, best-match tracking, result register.
  rlpm_scan #(
    .ENTRIES (ENTRIES)
  ) u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .wr       (tbl_wr),
    .rd       (tbl_rd),
    .rd_route (tbl_route),
    .rd_valid (tbl_valid)
  );

  // Route memory with registered read data and per-slot valid flops.
  rlpm_table #(
    .ENTRIES (ENTRIES)
  ) u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr       (tbl_wr),
    .rd       (tbl_rd),
    .rd_route (tbl_route),
    .rd_valid (tbl_valid)
  );

endmodule

`default_nettype wire

// ----- verif/route_longest_prefix_match_test.sv -----
// Self-checking testbench for the IPv4 longest-prefix-match route lookup.
module route_longest_prefix_match_test;
  timeunit 1ns;
  timeprecision 1ps;

  import rlpm_pkg::*;

  localparam int QUIET_LIMIT     = 3000;  // cycles with no word moving on either channel
  localparam int HOLD_OFF_CYCLES = 300;   // long receiver stall in the pressure phase
  localparam int DRAIN_CYCLES    = 40;
  localparam int RANDOM_PER_PHASE = 80;
  localparam int PHASES          = 5;

  // One request word as offered on in_ch.
  typedef struct packed {
    logic        op;
    logic [3:0]  slot;
    logic        entry_valid;
    logic [31:0] net_address;
    logic [31:0] net_mask;
    logic [31:0] gateway_address;
    logic [31:0] interface_address;
    logic [31:0] dest_ip;
    logic        local_origin;
  } route_word_t;

  // One result word as seen on out_ch.
  typedef struct packed {
    action_t     action;
    logic        route_found;
    logic [3:0]  route_slot;
    logic [5:0]  prefix_length;
    logic [31:0] hop_addr;
    logic [31:0] out_interface;
  } route_verdict_t;

  // Directed row: word, plus a hand-typed verdict where 'typed' is set.
  typedef struct packed {
    route_word_t    word;
    logic           typed;
    route_verdict_t want;
  } script_row_t;

  localparam route_verdict_t NO_CHECK = '0;
  localparam int SCRIPT_ROWS = 24;

  logic clk;
  logic rst_n;

  rlpm_in_if  in_ch ();
  rlpm_out_if out_ch ();

  route_longest_prefix_match dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Shadow of the route table, updated as each write word is accepted.
  logic        tbl_live [DEF_ENTRIES];
  logic [31:0] tbl_net  [DEF_ENTRIES];
  logic [31:0] tbl_mask [DEF_ENTRIES];
  logic [31:0] tbl_gw   [DEF_ENTRIES];
  logic [31:0] tbl_ifc  [DEF_ENTRIES];

  route_verdict_t routes_due [$];   // verdicts owed by the block, oldest first

  int   send_idle_pct;
  int   recv_stall_pct;
  logic rx_hold;
  int   miscompares;
  int   quiet_cycles;

  // Directed stimulus. Typed verdicts only where they are obvious:
  // empty table, default route, all-ones host route, no-match cases.
  script_row_t directed_script [SCRIPT_ROWS] = '{
    // empty table: non-local drops, local gives local, all else zero
    '{'{OP_LOOKUP, 4'd0, 1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0000_0000, 1'b0},
      1'b1, '{ACT_DROP, 1'b0, 4'd0, 6'd0, 32'h0, 32'h0}},
    '{'{OP_LOOKUP, 4'd0, 1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF, 1'b1},
      1'b1, '{ACT_LOCAL, 1'b0, 4'd0, 6'd0, 32'h0, 32'h0}},
    // default route 0/0 in slot 0, via gateway
    '{'{OP_WRITE, 4'd0, 1'b1, 32'h0000_0000, 32'h0000_0000, 32'h0A00_0001, 32'h0A00_0002,
        32'h0, 1'b0}, 1'b0, NO_CHECK},
    '{'{OP_LOOKUP, 4'd0, 1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 32'hC0A8_0105, 1'b0},
      1'b1, '{ACT_FORWARD, 1'b1, 4'd0, 6'd0, 32'h0A00_0001, 32'h0A00_0002}},
    // /32 host route of all ones in the top slot, directly connected
    '{'{OP_WRITE, 4'd15, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
        32'h0, 1'b0}, 1'b0, NO_CHECK},
    '{'{OP_LOOKUP, 4'd0, 1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF, 1'b0},
      1'b1, '{ACT_DELIVER, 1'b1, 4'd15, 6'd32, 32'hFFFF_FFFF, 32'hFFFF_FFFF}},
    // nested /16 and /24: longer prefix must win
    '{'{OP_WRITE, 4'd3, 1'b1, 32'hC0A8_0000, 32'hFFFF_0000, 32'h0000_0000, 32'hC0A8_0001,
        32'h0, 1'b0}, 1'b0, NO_CHECK},
    '{'{OP_WRITE, 4'd7, 1'b1, 32'hC0A8_0100, 32'hFFFF_FF00, 32'hC0A8_01FE, 32'hC0A8_0101,
        32'h0, 1'b0}, 1'b0, NO_CHECK},
    '{'{OP_LOOKUP, 4'd0, 1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 32'hC0A8_0105, 1'b0},
      1'b0, NO_CHECK},
    '{'{OP_LOOKUP, 4'd0, 1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 32'hC0A8_0205, 1'b1},
      1'b0, NO_CHECK},
    // equal /24 in a higher slot, host bits set in the network: tie keeps slot 7
    '{'{OP_WRITE, 4'd9, 1'b1, 32'hC0A8_01FF, 32'hFFFF_FF00, 32'h0000_0000, 32'h0A0A_0A0A,
        32'h0, 1'b0}, 1'b0, NO_CHECK},
    '{'{OP_LOOKUP, 4'd0, 1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 32'hC0A8_01AA, 1'b0},
      1'b0, NO_CHECK},
    // remove slot 7: slot 9 takes over
    '{'{OP_WRITE, 4'd7, 1'b0, 32'hC0A8_0100, 32'hFFFF_FF00, 32'hC0A8_01FE, 32'hC0A8_0101,
        32'h0, 1'b0}, 1'b0, NO_CHECK},
    '{'{OP_LOOKUP, 4'd0, 1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 32'hC0A8_01AA, 1'b0},
      1'b0, NO_CHECK},
    // remove the host route with new data stored; local lookup falls to default
    '{'{OP_WRITE, 4'd15, 1'b0, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
        32'h0, 1'b0}, 1'b0, NO_CHECK},
    '{'{OP_LOOKUP, 4'd0, 1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF, 1'b1},
      1'b0, NO_CHECK},
    // non-contiguous mask
    '{'{OP_WRITE, 4'd5, 1'b1, 32'hAAAA_AAAA, 32'h0F0F_0F0F, 32'h5555_5555, 32'h1234_5678,
        32'h0, 1'b0}, 1'b0, NO_CHECK},
    '{'{OP_LOOKUP, 4'd0, 1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h5A5A_5A5A, 1'b0},
      1'b0, NO_CHECK},
    // drop the default route: unmatched addresses now miss
    '{'{OP_WRITE, 4'd0, 1'b0, 32'h0000_0000, 32'h0000_0000, 32'h0A00_0001, 32'h0A00_0002,
        32'h0, 1'b0}, 1'b0, NO_CHECK},
    '{'{OP_LOOKUP, 4'd0, 1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h1234_5678, 1'b0},
      1'b1, '{ACT_DROP, 1'b0, 4'd0, 6'd0, 32'h0, 32'h0}},
    '{'{OP_LOOKUP, 4'd0, 1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h1234_5678, 1'b1},
      1'b1, '{ACT_LOCAL, 1'b0, 4'd0, 6'd0, 32'h0, 32'h0}},
    // lookup with every write field at all ones: they must be ignored
    '{'{OP_LOOKUP, 4'd15, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
        32'h0000_0000, 1'b0}, 1'b1, '{ACT_DROP, 1'b0, 4'd0, 6'd0, 32'h0, 32'h0}},
    // write with lookup fields at all ones: also ignored
    '{'{OP_WRITE, 4'd1, 1'b1, 32'h0A00_0000, 32'hFF00_0000, 32'h0000_0000, 32'h0A00_0001,
        32'hFFFF_FFFF, 1'b1}, 1'b0, NO_CHECK},
    '{'{OP_LOOKUP, 4'd0, 1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0A12_3456, 1'b0},
      1'b0, NO_CHECK}
  };

  // Best route for one destination against the shadow table.
  function automatic route_verdict_t resolve_route(input logic [31:0] dst,
                                                   input logic from_host);
    route_verdict_t v;
    logic           hit;
    int             best;
    int             best_len;
    int             len;
    v        = '0;
    hit      = 1'b0;
    best     = 0;
    best_len = 0;
    for (int i = 0; i < DEF_ENTRIES; i++) begin
      if (tbl_live[i] && ((dst & tbl_mask[i]) == (tbl_net[i] & tbl_mask[i]))) begin
        len = $countones(tbl_mask[i]);
        // strict compare keeps the lowest slot on a tie
        if (!hit || len > best_len) begin
          hit      = 1'b1;
          best     = i;
          best_len = len;
        end
      end
    end
    if (hit) begin
      v.route_found   = 1'b1;
      v.route_slot    = 4'(best);
      v.prefix_length = 6'(best_len);
      v.hop_addr      = (tbl_gw[best] != 32'h0) ? tbl_gw[best] : dst;
      v.out_interface = tbl_ifc[best];
      if (from_host)
        v.action = ACT_LOCAL;
      else
        v.action = (tbl_gw[best] != 32'h0) ? ACT_FORWARD : ACT_DELIVER;
    end else begin
      v.action = from_host ? ACT_LOCAL : ACT_DROP;
    end
    return v;
  endfunction

  // Random word. Networks share a few /16 bases so prefixes overlap, masks are
  // mostly contiguous, and most lookups aim inside some slot's prefix.
  function automatic route_word_t random_word();
    route_word_t w;
    int          plen;
    int          s;
    w.op                = ($urandom_range(0, 99) < 35) ? OP_WRITE : OP_LOOKUP;
    w.slot              = 4'($urandom);
    w.entry_valid       = ($urandom_range(0, 99) < 85);
    w.net_address       = $urandom;
    w.gateway_address   = ($urandom_range(0, 99) < 30) ? 32'h0 : 32'($urandom);
    w.interface_address = $urandom;
    w.dest_ip           = $urandom;
    w.local_origin      = ($urandom_range(0, 99) < 30);
    plen = $urandom_range(0, 32);
    if ($urandom_range(0, 99) < 80)
      w.net_mask = (plen == 0) ? 32'h0 : (32'hFFFF_FFFF << (32 - plen));
    else
      w.net_mask = $urandom;
    if ($urandom_range(0, 99) < 70) begin
      case ($urandom_range(0, 3))
        0:       w.net_address[31:16] = 16'h0A00;
        1:       w.net_address[31:16] = 16'hC0A8;
        2:       w.net_address[31:16] = 16'hAC10;
        default: w.net_address[31:16] = 16'hFFFF;
      endcase
    end
    if ($urandom_range(0, 99) < 75) begin
      s = $urandom_range(0, DEF_ENTRIES - 1);
      w.dest_ip = (tbl_net[s] & tbl_mask[s]) | (w.dest_ip & ~tbl_mask[s]);
    end
    return w;
  endfunction

  // Offer one word, hold it until taken, then record its effect.
  task automatic send_word(input route_word_t w, input logic typed,
                           input route_verdict_t want);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid             <= 1'b1;
    in_ch.op                <= w.op;
    in_ch.slot              <= w.slot;
    in_ch.entry_valid       <= w.entry_valid;
    in_ch.net_address       <= w.net_address;
    in_ch.net_mask          <= w.net_mask;
    in_ch.gateway_address   <= w.gateway_address;
    in_ch.interface_address <= w.interface_address;
    in_ch.dest_ip           <= w.dest_ip;
    in_ch.local_origin      <= w.local_origin;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    // word taken at this edge
    if (w.op == OP_WRITE) begin
      tbl_live[w.slot] = w.entry_valid;
      tbl_net[w.slot]  = w.net_address;
      tbl_mask[w.slot] = w.net_mask;
      tbl_gw[w.slot]   = w.gateway_address;
      tbl_ifc[w.slot]  = w.interface_address;
    end else begin
      routes_due.push_back(typed ? want : resolve_route(w.dest_ip, w.local_origin));
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result side: random stalls, forced low while the pressure hold is on.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= !rx_hold && ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Result checker: each word against the oldest owed verdict.
  always @(posedge clk) begin
    route_verdict_t got;
    route_verdict_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{action_t'(out_ch.action), out_ch.route_found, out_ch.route_slot,
              out_ch.prefix_length, out_ch.hop_addr, out_ch.out_interface};
      if (routes_due.size() == 0) begin
        miscompares++;
        if (miscompares <= 10)
          $display("unexpected result: act=%0d found=%0b slot=%0d len=%0d hop=%h ifc=%h",
                   got.action, got.route_found, got.route_slot, got.prefix_length,
                   got.hop_addr, got.out_interface);
      end else begin
        want = routes_due.pop_front();
        if (got !== want) begin
          miscompares++;
          if (miscompares <= 10) begin
            $display("mismatch: want act=%0d found=%0b slot=%0d len=%0d hop=%h ifc=%h",
                     want.action, want.route_found, want.route_slot, want.prefix_length,
                     want.hop_addr, want.out_interface);
            $display("          got  act=%0d found=%0b slot=%0d len=%0d hop=%h ifc=%h",
                     got.action, got.route_found, got.route_slot, got.prefix_length,
                     got.hop_addr, got.out_interface);
          end
        end
      end
    end
  end

  // Watchdog: ends a run where neither channel moves a word for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    int ph;
    int n;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    miscompares    = 0;
    quiet_cycles   = 0;
    rx_hold        <= 1'b0;
    for (int i = 0; i < DEF_ENTRIES; i++) begin
      tbl_live[i] = 1'b0;
      tbl_net[i]  = '0;
      tbl_mask[i] = '0;
      tbl_gw[i]   = '0;
      tbl_ifc[i]  = '0;
    end
    rst_n                   <= 1'b0;
    in_ch.valid             <= 1'b0;
    in_ch.op                <= OP_WRITE;
    in_ch.slot              <= '0;
    in_ch.entry_valid       <= 1'b0;
    in_ch.net_address       <= '0;
    in_ch.net_mask          <= '0;
    in_ch.gateway_address   <= '0;
    in_ch.interface_address <= '0;
    in_ch.dest_ip           <= '0;
    in_ch.local_origin      <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table, no idling
    for (int r = 0; r < SCRIPT_ROWS; r++)
      send_word(directed_script[r].word, directed_script[r].typed, directed_script[r].want);

    // random phases: clean, sender gaps, receiver stalls, both light, pressure
    for (ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 83; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 83; end
        3: begin send_idle_pct = 7;  recv_stall_pct = 7;  end
        default: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
          // long receiver hold while words keep coming: block fills and backs up
          fork
            begin
              rx_hold <= 1'b1;
              repeat (HOLD_OFF_CYCLES) @(posedge clk);
              rx_hold <= 1'b0;
            end
          join_none
        end
      endcase
      for (n = 0; n < RANDOM_PER_PHASE; n++)
        send_word(random_word(), 1'b0, NO_CHECK);
    end
    in_ch.valid <= 1'b0;

    while (routes_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (miscompares == 0 && routes_due.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
